// ===== hw/rtl/liqed_pkg.sv =====
// Shared constants and types for the lock-in I/Q detector.
// Used by the multiplier, the square-root unit, the top level and its checker.
// No dependencies.
package liqed_pkg;

   // Channel count and field widths.
   localparam int CHANNELS = 4;
   localparam int CH_W = 2;
   localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int SAMPLE_W = 16;
   localparam int REF_W = 16;
   localparam int WEIGHT_W = 16;
   localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd66;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 56;

   // Accumulators hold 16 fraction bits in 34 bits.
   localparam int ACC_W = 34;
   localparam int FRAC_W = 16;
   localparam int IQ_W = 17;
   localparam int AMP_W = 18;

   // Shared multiplier operand widths.
   localparam int MUL_A_W = 19;
   localparam int MUL_B_W = 17;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // Square root: 34-bit radicand, 17-bit root.
   localparam int RAD_W = 34;
   localparam int ROOT_W = RAD_W / 2;

   typedef logic signed [MUL_A_W-1:0] mul_a_type;
   typedef logic signed [MUL_B_W-1:0] mul_b_type;
   typedef logic signed [MUL_P_W-1:0] mul_p_type;

   // Request to and answer from the square-root unit.
   typedef struct packed {
      logic             start;
      logic [RAD_W-1:0] radicand;
   } root_req_type;

   typedef struct packed {
      logic              done;
      logic [ROOT_W-1:0] root;
   } root_rsp_type;

endpackage

// ===== hw/rtl/liqed_mul.sv =====
// Shared signed multiplier with a registered product.
// Depends on liqed_pkg for operand and product types.
module liqed_mul (
   input  logic                  clock,
   input  liqed_pkg::mul_a_type  op_a,
   input  liqed_pkg::mul_b_type  op_b,
   output liqed_pkg::mul_p_type  prod_ff
);
   import liqed_pkg::*;

   mul_p_type prod_in;

   // One signed product per cycle.
   always_comb begin
      prod_in = MUL_P_W'(op_a) * MUL_P_W'(op_b);
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// ===== hw/rtl/liqed_isqrt.sv =====
// Iterative floor square root, one root bit per cycle.
// Depends on liqed_pkg for widths and the request/answer structs.
module liqed_isqrt (
   input  logic                     clock,
   input  logic                     reset,
   input  liqed_pkg::root_req_type  root_req,
   output liqed_pkg::root_rsp_type  root_rsp
);
   import liqed_pkg::*;

   localparam int CNT_W = $clog2(ROOT_W);
   localparam int REM_W = ROOT_W + 2;
   localparam int SH_W = REM_W + 2;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [RAD_W-1:0] rad_ff, rad_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [SH_W-1:0]  shifted;
   logic [SH_W-1:0]  trial;

   // Bring down the next two radicand bits and try the next root bit.
   always_comb begin
      shifted  = {rem_ff, rad_ff[RAD_W-1 -: 2]};
      trial    = {2'b00, root_ff, 2'b01};
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rad_in   = rad_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      if (root_req.start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rad_in   = root_req.radicand;
         rem_in   = '0;
         root_in  = '0;
      end else if (busy_ff) begin
         if (shifted >= trial) begin
            rem_in  = REM_W'(shifted - trial);
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = REM_W'(shifted);
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
         rad_in   = {rad_ff[RAD_W-3:0], 2'b00};
         count_in = count_ff + 1'b1;
         if (count_ff == CNT_W'(ROOT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign root_rsp.done = done_ff;
   assign root_rsp.root = root_ff;

endmodule

// ===== hw/rtl/lockin_iq_ewma_detector_top.sv =====
// Lock-in I/Q detector top level: sequencer, per-channel averages, output register.
// Depends on liqed_pkg, liqed_mul and liqed_isqrt.
//
// Each request carries a channel in req_tuser and a sample with cosine and sine
// references in req_tdata. The block forms the two mixing products, moves the
// channel's in-phase and quadrature averages toward them by the weight set on
// the csr port, takes the floor square root of the sum of the squared integer
// parts and moves the amplitude average toward twice that root. One response per
// request returns the channel and the three integer parts. A new request is only
// taken once the last one has left the sequencer: every product goes through one
// shared 19x17 multiplier (two mixing products, two partial products for each
// of the three average updates, two squares), and the square root resolves one
// bit per cycle. A finished response waits in an output register while the
// next request is taken.
module lockin_iq_ewma_detector_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // sample [15:0], cos_ref [31:16], sin_ref [47:32]
   input  logic [liqed_pkg::REQ_DATA_W-1:0] req_tdata,
   // channel [1:0]
   input  logic [liqed_pkg::CH_W-1:0]       req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // in_phase [16:0], quadrature [33:17], amplitude [51:34], zero [55:52]
   output logic [liqed_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // channel_out [1:0]
   output logic [liqed_pkg::CH_W-1:0]       rsp_tuser,
   input  logic                             csr_wr_en,
   input  logic [liqed_pkg::WEIGHT_W-1:0]   csr_wr_data
);
   import liqed_pkg::*;

   // Sequencer states.
   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_MUL_I     = 4'd1;
   localparam logic [3:0] ST_MUL_Q     = 4'd2;
   localparam logic [3:0] ST_DIFF      = 4'd3;
   localparam logic [3:0] ST_MUL_HI    = 4'd4;
   localparam logic [3:0] ST_MUL_LO    = 4'd5;
   localparam logic [3:0] ST_ACC       = 4'd6;
   localparam logic [3:0] ST_WB        = 4'd7;
   localparam logic [3:0] ST_SQ_I      = 4'd8;
   localparam logic [3:0] ST_SQ_Q      = 4'd9;
   localparam logic [3:0] ST_SQ_SUM    = 4'd10;
   localparam logic [3:0] ST_ROOT_GO   = 4'd11;
   localparam logic [3:0] ST_ROOT_WAIT = 4'd12;
   localparam logic [3:0] ST_DONE      = 4'd13;

   // Which average the update pass is working on.
   localparam logic [1:0] SEL_I = 2'd0;
   localparam logic [1:0] SEL_Q = 2'd1;
   localparam logic [1:0] SEL_A = 2'd2;

   localparam int WIDE_W = ACC_W + 1;
   localparam int MACC_W = 53;
   localparam int LO_W = 18;

   logic [3:0]                 state_ff, state_in;
   logic [1:0]                 sel_ff, sel_in;
   logic [CH_W-1:0]            ch_ff, ch_in;
   logic                       bad_ff, bad_in;
   logic [SAMPLE_W-1:0]        sample_ff, sample_in;
   logic [REF_W-1:0]           cos_ff, cos_in;
   logic [REF_W-1:0]           sin_ff, sin_in;
   logic [WEIGHT_W-1:0]        weight_ff, weight_in;
   logic signed [IQ_W-1:0]     pi_ff, pi_in;
   logic signed [IQ_W-1:0]     pq_ff, pq_in;
   logic signed [WIDE_W-1:0]   d_ff, d_in;
   logic signed [MACC_W-1:0]   macc_ff, macc_in;
   logic [ROOT_W-1:0]          m_ff, m_in;
   logic [ACC_W-1:0]           acc_i_ff [CHANNELS];
   logic [ACC_W-1:0]           acc_i_in [CHANNELS];
   logic [ACC_W-1:0]           acc_q_ff [CHANNELS];
   logic [ACC_W-1:0]           acc_q_in [CHANNELS];
   logic [ACC_W-1:0]           acc_a_ff [CHANNELS];
   logic [ACC_W-1:0]           acc_a_in [CHANNELS];
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]      rsp_data_ff, rsp_data_in;
   logic [CH_W-1:0]            rsp_user_ff, rsp_user_in;

   logic [CH_IDX_W-1:0]        idx;
   logic signed [WIDE_W-1:0]   acc_cur;
   logic signed [WIDE_W-1:0]   target;
   logic signed [MACC_W-1:0]   delta;
   logic signed [WIDE_W-1:0]   acc_new;
   logic signed [IQ_W-1:0]     ii;
   logic signed [IQ_W-1:0]     qi;
   logic [AMP_W-1:0]           amp;
   logic                       req_fire;
   logic                       rsp_free;
   mul_a_type                  op_a;
   mul_b_type                  op_b;
   mul_p_type                  prod_ff;
   root_req_type               root_req;
   root_rsp_type               root_rsp;

   liqed_mul u_mul (
      .clock   (clock),
      .op_a    (op_a),
      .op_b    (op_b),
      .prod_ff (prod_ff)
   );

   liqed_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .root_req (root_req),
      .root_rsp (root_rsp)
   );

   // Selected channel's averages and the operands of the current update pass.
   always_comb begin
      idx = CH_IDX_W'(ch_ff);
      ii  = acc_i_ff[idx][FRAC_W +: IQ_W];
      qi  = acc_q_ff[idx][FRAC_W +: IQ_W];
      amp = acc_a_ff[idx][FRAC_W +: AMP_W];
      unique case (sel_ff)
         SEL_I: begin
            acc_cur = {acc_i_ff[idx][ACC_W-1], acc_i_ff[idx]};
            target  = {{2{pi_ff[IQ_W-1]}}, pi_ff, {FRAC_W{1'b0}}};
         end
         SEL_Q: begin
            acc_cur = {acc_q_ff[idx][ACC_W-1], acc_q_ff[idx]};
            target  = {{2{pq_ff[IQ_W-1]}}, pq_ff, {FRAC_W{1'b0}}};
         end
         default: begin
            acc_cur = {1'b0, acc_a_ff[idx]};
            target  = {1'b0, m_ff, {(FRAC_W + 1){1'b0}}};
         end
      endcase
      delta   = macc_ff >>> FRAC_W;
      acc_new = acc_cur + WIDE_W'(delta);
   end

   // Operand selection for the shared multiplier.
   always_comb begin
      unique case (state_ff)
         ST_MUL_I: begin
            op_a = {3'b000, sample_ff};
            op_b = {cos_ff[REF_W-1], cos_ff};
         end
         ST_MUL_Q: begin
            op_a = {3'b000, sample_ff};
            op_b = {sin_ff[REF_W-1], sin_ff};
         end
         ST_MUL_HI: begin
            op_a = {{2{d_ff[WIDE_W-1]}}, d_ff[WIDE_W-1:LO_W]};
            op_b = {1'b0, weight_ff};
         end
         ST_MUL_LO: begin
            op_a = {1'b0, d_ff[LO_W-1:0]};
            op_b = {1'b0, weight_ff};
         end
         ST_SQ_I: begin
            op_a = {{2{ii[IQ_W-1]}}, ii};
            op_b = ii;
         end
         ST_SQ_Q: begin
            op_a = {{2{qi[IQ_W-1]}}, qi};
            op_b = qi;
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   assign req_fire = req_tvalid && req_tready;
   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign root_req.start = (state_ff == ST_ROOT_GO);
   assign root_req.radicand = RAD_W'(macc_ff);

   // Sequencer and datapath next values.
   always_comb begin
      state_in     = state_ff;
      sel_in       = sel_ff;
      ch_in        = ch_ff;
      bad_in       = bad_ff;
      sample_in    = sample_ff;
      cos_in       = cos_ff;
      sin_in       = sin_ff;
      weight_in    = csr_wr_en ? csr_wr_data : weight_ff;
      pi_in        = pi_ff;
      pq_in        = pq_ff;
      d_in         = d_ff;
      macc_in      = macc_ff;
      m_in         = m_ff;
      acc_i_in     = acc_i_ff;
      acc_q_in     = acc_q_ff;
      acc_a_in     = acc_a_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               ch_in     = req_tuser;
               bad_in    = 32'(req_tuser) >= CHANNELS;
               sample_in = req_tdata[0 +: SAMPLE_W];
               cos_in    = req_tdata[SAMPLE_W +: REF_W];
               sin_in    = req_tdata[SAMPLE_W + REF_W +: REF_W];
               sel_in    = SEL_I;
               state_in  = (32'(req_tuser) >= CHANNELS) ? ST_DONE : ST_MUL_I;
            end
         end
         ST_MUL_I: begin
            state_in = ST_MUL_Q;
         end
         ST_MUL_Q: begin
            // Cosine product, floor-shifted by 15.
            pi_in    = prod_ff[15 +: IQ_W];
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            // Sine product arrives during the in-phase pass.
            if (sel_ff == SEL_I) begin
               pq_in = prod_ff[15 +: IQ_W];
            end
            d_in     = target - acc_cur;
            state_in = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            state_in = ST_MUL_LO;
         end
         ST_MUL_LO: begin
            macc_in  = MACC_W'(prod_ff) <<< LO_W;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            macc_in  = macc_ff + MACC_W'(prod_ff);
            state_in = ST_WB;
         end
         ST_WB: begin
            unique case (sel_ff)
               SEL_I: begin
                  acc_i_in[idx] = ACC_W'(acc_new);
                  sel_in        = SEL_Q;
                  state_in      = ST_DIFF;
               end
               SEL_Q: begin
                  acc_q_in[idx] = ACC_W'(acc_new);
                  state_in      = ST_SQ_I;
               end
               default: begin
                  acc_a_in[idx] = ACC_W'(acc_new);
                  state_in      = ST_DONE;
               end
            endcase
         end
         ST_SQ_I: begin
            state_in = ST_SQ_Q;
         end
         ST_SQ_Q: begin
            macc_in  = MACC_W'(prod_ff);
            state_in = ST_SQ_SUM;
         end
         ST_SQ_SUM: begin
            macc_in  = macc_ff + MACC_W'(prod_ff);
            state_in = ST_ROOT_GO;
         end
         ST_ROOT_GO: begin
            state_in = ST_ROOT_WAIT;
         end
         ST_ROOT_WAIT: begin
            if (root_rsp.done) begin
               m_in     = root_rsp.root;
               sel_in   = SEL_A;
               state_in = ST_DIFF;
            end
         end
         ST_DONE: begin
            // Hand the response over once the output register is free.
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = ch_ff;
               if (bad_ff) begin
                  rsp_data_in = '0;
               end else begin
                  rsp_data_in = {4'b0000, amp, qi, ii};
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sel_ff       <= SEL_I;
         weight_ff    <= WEIGHT_RESET;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < CHANNELS; k++) begin
            acc_i_ff[k] <= '0;
            acc_q_ff[k] <= '0;
            acc_a_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         sel_ff       <= sel_in;
         weight_ff    <= weight_in;
         rsp_valid_ff <= rsp_valid_in;
         acc_i_ff     <= acc_i_in;
         acc_q_ff     <= acc_q_in;
         acc_a_ff     <= acc_a_in;
      end
      ch_ff       <= ch_in;
      bad_ff      <= bad_in;
      sample_ff   <= sample_in;
      cos_ff      <= cos_in;
      sin_ff      <= sin_in;
      pi_ff       <= pi_in;
      pq_ff       <= pq_in;
      d_ff        <= d_in;
      macc_ff     <= macc_in;
      m_ff        <= m_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ===== hw/rtl/liqed_checker.sv =====
// Port-level checks for the lock-in I/Q detector, bound to the top level.
// Depends on liqed_pkg and lockin_iq_ewma_detector_top.
module liqed_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [liqed_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [liqed_pkg::CH_W-1:0]       rsp_tuser
);
   import liqed_pkg::*;

   // A stalled response holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   // One request at a time: the block is busy right after taking one.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // Reset leaves no response pending once it is released.
   assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_tvalid)
      else $error("response pending after reset");

   // The padding above the amplitude stays zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_DATA_W-1:52] == '0)
      else $error("response padding not zero");

endmodule

bind lockin_iq_ewma_detector_top liqed_checker u_checker (.*);
